// ----- src/wrt_pkg.sv -----
// shared types and constants for the wildcard rule table
package wrt_pkg;

    localparam int RULE_SLOTS_DEF = 32;
    localparam logic [2:0] PART_ANY = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NODEL = 2'd2;

    localparam logic CMD_MERGE = 1'b0;
    localparam logic CMD_CHOOSE = 1'b1;

    localparam logic [1:0] REG_ANY_NET = 2'd0;
    localparam logic [1:0] REG_INVALID = 2'd1;
    localparam logic [1:0] REG_NULL = 2'd2;

    typedef struct packed {
        logic        command;
        logic [31:0] net_id;
        logic [2:0]  from_part;
        logic [2:0]  to_part;
        logic [15:0] sec_flavor;
        logic [7:0]  bulk_hash;
        logic [7:0]  bulk_cipher;
        logic [31:0] flavor_flags;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        matched;
        logic [15:0] out_sec_flavor;
        logic [7:0]  out_bulk_hash;
        logic [7:0]  out_bulk_cipher;
        logic [31:0] out_flags;
        logic [5:0]  rule_total;
    } out_item_t;

    // one stored rule
    typedef struct packed {
        logic [31:0] net;
        logic [5:0]  parts;
        logic [31:0] flavor;
        logic [31:0] flagbits;
    } rule_t;

    // per-cycle command from the controller to every cell
    typedef struct packed {
        logic write_here;
        logic shift_up;
        logic shift_down;
        logic rotate;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT
    } state_t;

endpackage

// ----- src/wildcard_rule_table.sv -----
// top level: rule cell chain with its scan controller and config registers
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready, payload in_item
//  out     | output    | out_valid / out_ready, payload out_item
//  cfg     | input     | cfg_we, cfg_index, cfg_data
// out_valid rises once an item has gone through a full rotation of the chain,
// an end-of-scan step and an apply step
// after the result leaves, the table returns to idle before it takes the next
// item, so items do not overlap and out_ready stalls add to each item's time
// reset clears the rule count and presets config; rule slots need no clearing
// out_valid holds the result while out_ready is low
module wildcard_rule_table #(
    parameter int RULE_SLOTS = wrt_pkg::RULE_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wrt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output wrt_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CW = $clog2(RULE_SLOTS + 1);
    localparam int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    logic [31:0] any_net_reg;
    logic [15:0] invalid_reg, null_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_net_reg <= '1;
            invalid_reg <= '1;
            null_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wrt_pkg::REG_ANY_NET: any_net_reg <= cfg_data;
                wrt_pkg::REG_INVALID: invalid_reg <= cfg_data[15:0];
                wrt_pkg::REG_NULL:    null_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    wrt_pkg::rule_t     rules [RULE_SLOTS];
    wrt_pkg::rule_t     new_rule;
    wrt_pkg::cell_ctl_t ctl;
    logic [IW-1:0]      pos;
    logic [CW-1:0]      count;

    wrt_ctrl #(.RULE_SLOTS(RULE_SLOTS), .CW(CW), .IW(IW)) u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .in_item,
        .out_valid, .out_ready, .out_item,
        .any_net(any_net_reg), .invalid_fl(invalid_reg), .null_fl(null_reg),
        .head(rules[0]), .ctl, .pos, .count, .new_rule
    );

    for (genvar i = 0; i < RULE_SLOTS; i++)
    begin : g_cell
        logic sel;
        always_comb
        begin
            if (ctl.shift_up)
                sel = ((CW + 1)'(i) >= (CW + 1)'(pos)) && ((CW + 1)'(i) <= (CW + 1)'(count));
            else if (ctl.shift_down)
                sel = ((CW + 1)'(i) >= (CW + 1)'(pos)) && ((CW + 1)'(i) + 1'b1 < (CW + 1)'(count));
            else
                sel = ((CW + 1)'(i) == (CW + 1)'(pos));
        end
        // the insertion slot takes the new rule while the slots above shift up
        wrt_cell u_cell (
            .clk,
            .ctl(ctl),
            .sel(sel),
            .new_rule(new_rule),
            .from_below(((CW + 1)'(i) == (CW + 1)'(pos)) ? new_rule
                        : rules[(i == 0) ? 0 : i - 1]),
            .from_above(rules[(i + 1) % RULE_SLOTS]),
            .rule(rules[i])
        );
    end

endmodule

// ----- src/wrt_cell.sv -----
// one rule slot: holds a rule, shifts with its neighbors, rotates for the scan
module wrt_cell (
    input  logic               clk,
    input  wrt_pkg::cell_ctl_t ctl,
    input  logic               sel,
    input  wrt_pkg::rule_t     new_rule,
    input  wrt_pkg::rule_t     from_below,
    input  wrt_pkg::rule_t     from_above,
    output wrt_pkg::rule_t     rule
);

    wrt_pkg::rule_t rule_reg;
    wrt_pkg::rule_t rule_next;

    always_comb
    begin
        rule_next = rule_reg;
        if (ctl.rotate)
            rule_next = from_above;
        else if (ctl.write_here && sel)
            rule_next = new_rule;
        else if (ctl.shift_up && sel)
            rule_next = from_below;
        else if (ctl.shift_down && sel)
            rule_next = from_above;
    end

    always_ff @(posedge clk)
    begin
        rule_reg <= rule_next;
    end

    assign rule = rule_reg;

endmodule

// ----- src/wrt_ctrl.sv -----
// scan and update controller reading the head of the rotating chain
module wrt_ctrl #(
    parameter int RULE_SLOTS = wrt_pkg::RULE_SLOTS_DEF,
    parameter int CW = $clog2(RULE_SLOTS + 1),
    parameter int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wrt_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output wrt_pkg::out_item_t  out_item,
    input  logic [31:0]         any_net,
    input  logic [15:0]         invalid_fl,
    input  logic [15:0]         null_fl,
    input  wrt_pkg::rule_t      head,
    output wrt_pkg::cell_ctl_t  ctl,
    output logic [IW-1:0]       pos,
    output logic [CW-1:0]       count,
    output wrt_pkg::rule_t      new_rule
);

    wrt_pkg::state_t state_reg, state_next;
    wrt_pkg::in_item_t item_reg, item_next;
    wrt_pkg::out_item_t res_reg, res_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW:0]   step_reg, step_next;
    logic [CW-1:0] hit_reg, hit_next;
    logic          found_reg, found_next;
    logic          stop_reg, stop_next;

    logic [5:0] parts;
    logic       net_specific, dir_specific, del, in_range, rspec;
    logic       c_hit, m_hit, m_stop;

    assign parts = {item_reg.to_part, item_reg.from_part};
    assign net_specific = item_reg.net_id != any_net;
    assign dir_specific = (parts[2:0] != wrt_pkg::PART_ANY)
                          || (parts[5:3] != wrt_pkg::PART_ANY);
    assign del = item_reg.sec_flavor == invalid_fl;
    assign rspec = (head.parts[2:0] != wrt_pkg::PART_ANY)
                   || (head.parts[5:3] != wrt_pkg::PART_ANY);
    assign in_range = step_reg < (IW + 1)'(count_reg);
    assign c_hit = (item_reg.net_id == any_net || head.net == any_net
                    || item_reg.net_id == head.net)
                   && (item_reg.from_part == wrt_pkg::PART_ANY
                       || head.parts[2:0] == wrt_pkg::PART_ANY
                       || item_reg.from_part == head.parts[2:0]);
    assign m_hit = head.net == item_reg.net_id && head.parts == parts;
    assign m_stop = (head.net != item_reg.net_id) ? (net_specific && head.net == any_net)
                    : (head.parts != parts && dir_specific && !rspec);

    assign new_rule = '{net: item_reg.net_id, parts: parts,
                        flavor: {item_reg.bulk_cipher, item_reg.bulk_hash, item_reg.sec_flavor},
                        flagbits: item_reg.flavor_flags};
    assign pos = hit_reg[IW-1:0];
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wrt_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        step_reg  <= step_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
        stop_reg  <= stop_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        res_next = res_reg;
        count_next = count_reg;
        step_next = step_reg;
        hit_next = hit_reg;
        found_next = found_reg;
        stop_next = stop_reg;
        ctl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            wrt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_item;
                    step_next = '0;
                    hit_next = '0;
                    found_next = 1'b0;
                    stop_next = 1'b0;
                    res_next = '0;
                    res_next.status = wrt_pkg::ST_DONE;
                    res_next.out_sec_flavor = (in_item.command == wrt_pkg::CMD_CHOOSE)
                                              ? null_fl : 16'd0;
                    state_next = wrt_pkg::S_SCAN;
                end
            end
            wrt_pkg::S_SCAN:
            begin
                // full rotation keeps slot order intact
                if (step_reg == (IW + 1)'(RULE_SLOTS))
                    state_next = wrt_pkg::S_APPLY;
                else
                begin
                    ctl.rotate = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (in_range && !found_reg && !stop_reg)
                    begin
                        if (item_reg.command == wrt_pkg::CMD_CHOOSE)
                        begin
                            if (c_hit)
                            begin
                                found_next = 1'b1;
                                res_next.out_sec_flavor = head.flavor[15:0];
                                res_next.out_bulk_hash = head.flavor[23:16];
                                res_next.out_bulk_cipher = head.flavor[31:24];
                                res_next.out_flags = head.flagbits;
                            end
                        end
                        else if (m_hit)
                            found_next = 1'b1;
                        else if (m_stop)
                            stop_next = 1'b1;
                        else
                            hit_next = hit_reg + 1'b1;
                    end
                    else if (!found_reg && !stop_reg && !in_range)
                        stop_next = 1'b1;
                end
            end
            wrt_pkg::S_APPLY:
            begin
                if (item_reg.command == wrt_pkg::CMD_MERGE)
                begin
                    if (found_reg && del)
                    begin
                        ctl.shift_down = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else if (found_reg)
                        ctl.write_here = 1'b1;
                    else if (del)
                        res_next.status = wrt_pkg::ST_NODEL;
                    else if (count_reg == CW'(RULE_SLOTS))
                        res_next.status = wrt_pkg::ST_FULL;
                    else
                    begin
                        ctl.shift_up = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                res_next.matched = found_reg;
                state_next = wrt_pkg::S_OUT;
            end
            wrt_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = wrt_pkg::S_IDLE;
            end
            default:
                state_next = wrt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        out_item = res_reg;
        out_item.rule_total = 6'(count_reg);
    end

    property p_count_max;
        @(posedge clk) disable iff (!rst_n) count_reg <= CW'(RULE_SLOTS);
    endproperty
    a_count_max: assert property (p_count_max) else $error("rule count above slots");

    property p_count_idle;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == wrt_pkg::S_SCAN || state_reg == wrt_pkg::S_OUT) |=> $stable(count_reg);
    endproperty
    a_count_idle: assert property (p_count_idle) else $error("count moved outside apply");

    property p_one_op;
        @(posedge clk) disable iff (!rst_n)
            $onehot0({ctl.write_here, ctl.shift_up, ctl.shift_down, ctl.rotate});
    endproperty
    a_one_op: assert property (p_one_op) else $error("conflicting cell commands");

endmodule
